### src/spc_pkg.sv
// Shared types and constants for the segment/plane clipper.
// Used by every module of the block; depends on nothing.
package spc_pkg;

   // Coordinate format: signed Q16.16 in a 32-bit word
   localparam int CW = 32;
   localparam int FB = 16;

   // Raw coordinate*normal product
   localparam int PW = 2 * CW;
   // Dot product: three floored products summed, with two bits of growth
   localparam int DW = PW - FB + 2;
   // Numerator/denominator width and their magnitudes
   localparam int NW = DW + 1;
   localparam int MW = NW;
   // Quotient bits retired per divider stage, and the stage count
   localparam int QB_PER_STAGE = 2;
   localparam int DIV_STAGES = FB / QB_PER_STAGE;
   // Interpolation: (B - A) times the quotient
   localparam int DIFW = CW + 1;
   localparam int IPW = DIFW + FB + 1;

   // Register indexes on the CSR port
   localparam int IDXW = 8;
   localparam logic [IDXW-1:0] REG_NORMAL_X = 8'd0;
   localparam logic [IDXW-1:0] REG_NORMAL_Y = 8'd1;
   localparam logic [IDXW-1:0] REG_NORMAL_Z = 8'd2;
   localparam logic [IDXW-1:0] REG_PLANE_OFS = 8'd3;

   // Segment endpoints carried through the pipe
   typedef struct packed {
      logic [2:0][CW-1:0] a;
      logic [2:0][CW-1:0] b;
   } seg_type;

   // Classification decided ahead of the divider
   typedef struct packed {
      logic need_div;  // crossing strictly inside, quotient required
      logic kept_fix;  // kept flag when no division is needed
      logic kept_db;   // B's side test, used when the quotient is zero
      logic repl_a;    // A lies behind the plane
   } ctl_type;

   // Finished result
   typedef struct packed {
      logic    kept;
      seg_type seg;
   } res_type;

endpackage

### src/spc_dot.sv
// Dot products against the plane normal and crossing classification.
// Three stages: products, floored sum, numerator/denominator compare. Uses spc_pkg.
module spc_dot (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_v,
   input  spc_pkg::seg_type               in_seg,
   input  logic [2:0][spc_pkg::CW-1:0]    nrm,
   input  logic [spc_pkg::CW-1:0]         ofs,
   output logic                           out_v,
   output spc_pkg::seg_type               out_seg,
   output spc_pkg::ctl_type               out_ctl,
   output logic [spc_pkg::MW-1:0]         out_nm,
   output logic [spc_pkg::MW-1:0]         out_dm
);

   // Stage 1: six exact products
   logic                                  v1_ff;
   spc_pkg::seg_type                      seg1_ff;
   logic signed [spc_pkg::PW-1:0]         pa_ff [3];
   logic signed [spc_pkg::PW-1:0]         pb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg1_ff <= in_seg;
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= $signed(in_seg.a[i]) * $signed(nrm[i]);
            pb_ff[i] <= $signed(in_seg.b[i]) * $signed(nrm[i]);
         end
      end
   end

   // Stage 2: floor each product by FB and sum
   logic                                  v2_ff;
   spc_pkg::seg_type                      seg2_ff;
   logic signed [spc_pkg::DW-1:0]         da_ff, da_in;
   logic signed [spc_pkg::DW-1:0]         db_ff, db_in;

   always_comb begin
      da_in = '0;
      db_in = '0;
      for (int i = 0; i < 3; i++) begin
         da_in = da_in + {{2{pa_ff[i][spc_pkg::PW-1]}}, pa_ff[i][spc_pkg::PW-1:spc_pkg::FB]};
         db_in = db_in + {{2{pb_ff[i][spc_pkg::PW-1]}}, pb_ff[i][spc_pkg::PW-1:spc_pkg::FB]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg2_ff <= seg1_ff;
         da_ff   <= da_in;
         db_ff   <= db_in;
      end
   end

   // Stage 3: num = d - dotA, den = dotB - dotA, side tests, magnitudes
   logic                                  v3_ff;
   spc_pkg::seg_type                      seg3_ff;
   spc_pkg::ctl_type                      ctl_ff, ctl_in;
   logic [spc_pkg::MW-1:0]                nm_ff, nm_in;
   logic [spc_pkg::MW-1:0]                dm_ff, dm_in;
   logic signed [spc_pkg::DW-1:0]         ofs_ext;
   logic signed [spc_pkg::NW-1:0]         num, den;
   logic                                  ge_a, ge_b;

   always_comb begin
      ofs_ext = {{(spc_pkg::DW-spc_pkg::CW){ofs[spc_pkg::CW-1]}}, ofs};
      num     = {ofs_ext[spc_pkg::DW-1], ofs_ext} - {da_ff[spc_pkg::DW-1], da_ff};
      den     = {db_ff[spc_pkg::DW-1], db_ff} - {da_ff[spc_pkg::DW-1], da_ff};
      nm_in   = num[spc_pkg::NW-1] ? spc_pkg::MW'(-num) : spc_pkg::MW'(num);
      dm_in   = den[spc_pkg::NW-1] ? spc_pkg::MW'(-den) : spc_pkg::MW'(den);
      ge_a    = (da_ff >= ofs_ext);
      ge_b    = (db_ff >= ofs_ext);

      ctl_in.need_div = 1'b0;
      ctl_in.kept_fix = ge_a;
      ctl_in.kept_db  = ge_b;
      ctl_in.repl_a   = !ge_a;
      if (da_ff == db_ff) begin
         ctl_in.kept_fix = ge_a;
      end else if (num == '0 || (num[spc_pkg::NW-1] != den[spc_pkg::NW-1])) begin
         ctl_in.kept_fix = ge_b;
      end else if (nm_in >= dm_in) begin
         ctl_in.kept_fix = ge_a;
      end else begin
         ctl_in.need_div = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg3_ff <= seg2_ff;
         ctl_ff  <= ctl_in;
         nm_ff   <= nm_in;
         dm_ff   <= dm_in;
      end
   end

   assign out_v   = v3_ff;
   assign out_seg = seg3_ff;
   assign out_ctl = ctl_ff;
   assign out_nm  = nm_ff;
   assign out_dm  = dm_ff;

endmodule

### src/spc_div.sv
// Pipelined restoring divider for the crossing parameter t = num/den (num < den).
// Retires two quotient bits per stage over DIV_STAGES stages. Uses spc_pkg.
module spc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_v,
   input  spc_pkg::seg_type           in_seg,
   input  spc_pkg::ctl_type           in_ctl,
   input  logic [spc_pkg::MW-1:0]     in_nm,
   input  logic [spc_pkg::MW-1:0]     in_dm,
   output logic                       out_v,
   output spc_pkg::seg_type           out_seg,
   output spc_pkg::ctl_type           out_ctl,
   output logic [spc_pkg::FB-1:0]     out_q
);

   localparam int N = spc_pkg::DIV_STAGES;

   logic                       v_ff   [N];
   spc_pkg::seg_type           seg_ff [N];
   spc_pkg::ctl_type           ctl_ff [N];
   logic [spc_pkg::MW-1:0]     rem_ff [N];
   logic [spc_pkg::MW-1:0]     dm_ff  [N];
   logic [spc_pkg::FB-1:0]     q_ff   [N];

   for (genvar g = 0; g < N; g++) begin : g_stage
      logic                       v_p;
      spc_pkg::seg_type           seg_p;
      spc_pkg::ctl_type           ctl_p;
      logic [spc_pkg::MW-1:0]     rem_p, dm_p, rem_in;
      logic [spc_pkg::FB-1:0]     q_p, q_in;
      logic [spc_pkg::MW:0]       r1, r2;
      logic                       b1, b2;

      if (g == 0) begin : g_first
         assign v_p   = in_v;
         assign seg_p = in_seg;
         assign ctl_p = in_ctl;
         assign rem_p = in_nm;
         assign dm_p  = in_dm;
         assign q_p   = '0;
      end else begin : g_next
         assign v_p   = v_ff[g-1];
         assign seg_p = seg_ff[g-1];
         assign ctl_p = ctl_ff[g-1];
         assign rem_p = rem_ff[g-1];
         assign dm_p  = dm_ff[g-1];
         assign q_p   = q_ff[g-1];
      end

      // Two shift-compare-subtract steps
      always_comb begin
         r1 = {rem_p, 1'b0};
         b1 = (r1 >= {1'b0, dm_p});
         if (b1) begin
            r1 = r1 - {1'b0, dm_p};
         end
         r2 = {r1[spc_pkg::MW-1:0], 1'b0};
         b2 = (r2 >= {1'b0, dm_p});
         if (b2) begin
            r2 = r2 - {1'b0, dm_p};
         end
         rem_in = r2[spc_pkg::MW-1:0];
         q_in   = {q_p[spc_pkg::FB-3:0], b1, b2};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (adv) begin
            v_ff[g] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            seg_ff[g] <= seg_p;
            ctl_ff[g] <= ctl_p;
            rem_ff[g] <= rem_in;
            dm_ff[g]  <= dm_p;
            q_ff[g]   <= q_in;
         end
      end
   end

   assign out_v   = v_ff[N-1];
   assign out_seg = seg_ff[N-1];
   assign out_ctl = ctl_ff[N-1];
   assign out_q   = q_ff[N-1];

endmodule

### src/spc_interp.sv
// Crossing point A + trunc((B - A) * t) and endpoint selection.
// Two stages: multiply, then shift/add/select. Uses spc_pkg.
module spc_interp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_v,
   input  spc_pkg::seg_type           in_seg,
   input  spc_pkg::ctl_type           in_ctl,
   input  logic [spc_pkg::FB-1:0]     in_q,
   output logic                       out_v,
   output spc_pkg::res_type           out_res
);

   // Stage 1: per-axis products
   logic                              v1_ff;
   spc_pkg::seg_type                  seg1_ff;
   spc_pkg::ctl_type                  ctl1_ff;
   logic                              qz1_ff;
   logic signed [spc_pkg::IPW-1:0]    prod_ff [3];
   logic signed [spc_pkg::DIFW-1:0]   diff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = {in_seg.b[i][spc_pkg::CW-1], in_seg.b[i]}
                 - {in_seg.a[i][spc_pkg::CW-1], in_seg.a[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg1_ff <= in_seg;
         ctl1_ff <= in_ctl;
         qz1_ff  <= (in_q == '0);
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= diff[i] * $signed({1'b0, in_q});
         end
      end
   end

   // Stage 2: truncate toward zero, add A, pick the replaced endpoint
   logic                                   v2_ff;
   spc_pkg::res_type                       res_ff, res_in;
   logic signed [spc_pkg::IPW-1:0]         adj [3];
   logic signed [spc_pkg::IPW-spc_pkg::FB-1:0] step [3];
   logic signed [spc_pkg::IPW-spc_pkg::FB-1:0] cp [3];
   logic                                   do_cross;

   always_comb begin
      do_cross    = ctl1_ff.need_div && !qz1_ff;
      res_in.seg  = seg1_ff;
      if (ctl1_ff.need_div) begin
         res_in.kept = qz1_ff ? ctl1_ff.kept_db : 1'b1;
      end else begin
         res_in.kept = ctl1_ff.kept_fix;
      end
      for (int i = 0; i < 3; i++) begin
         adj[i]  = prod_ff[i] + (prod_ff[i][spc_pkg::IPW-1] ?
                   spc_pkg::IPW'((1 << spc_pkg::FB) - 1) : '0);
         step[i] = adj[i][spc_pkg::IPW-1:spc_pkg::FB];
         cp[i]   = step[i] + {{(spc_pkg::IPW-spc_pkg::FB-spc_pkg::CW)
                   {seg1_ff.a[i][spc_pkg::CW-1]}}, seg1_ff.a[i]};
         if (do_cross) begin
            if (ctl1_ff.repl_a) begin
               res_in.seg.a[i] = cp[i][spc_pkg::CW-1:0];
            end else begin
               res_in.seg.b[i] = cp[i][spc_pkg::CW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign out_v   = v2_ff;
   assign out_res = res_ff;

endmodule

### src/segment_plane_clip_core.sv
// Segment/plane clipper, top level: CSR bank, pipeline, output register and skid.
// Request accept to result valid passes through the dot, divide and interpolate stages and the
// output register. Throughput: one request per cycle while the skid slot is free, set by the
// pipelined divider retiring two quotient bits per stage.
// Reset (synchronous, active high) empties the pipe and clears all four registers.
// Uses spc_pkg, spc_dot, spc_div and spc_interp.
module segment_plane_clip_core (
   input  logic                         clock,
   input  logic                         reset,
   // CSR write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [spc_pkg::IDXW-1:0]     csr_index,
   input  logic [spc_pkg::CW-1:0]       csr_data,
   // Request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [spc_pkg::CW-1:0]       req_a_x,
   input  logic [spc_pkg::CW-1:0]       req_a_y,
   input  logic [spc_pkg::CW-1:0]       req_a_z,
   input  logic [spc_pkg::CW-1:0]       req_b_x,
   input  logic [spc_pkg::CW-1:0]       req_b_y,
   input  logic [spc_pkg::CW-1:0]       req_b_z,
   // Result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_kept,
   output logic [spc_pkg::CW-1:0]       rsp_out_a_x,
   output logic [spc_pkg::CW-1:0]       rsp_out_a_y,
   output logic [spc_pkg::CW-1:0]       rsp_out_a_z,
   output logic [spc_pkg::CW-1:0]       rsp_out_b_x,
   output logic [spc_pkg::CW-1:0]       rsp_out_b_y,
   output logic [spc_pkg::CW-1:0]       rsp_out_b_z
);

   // CSR bank
   logic [2:0][spc_pkg::CW-1:0]  nrm_ff;
   logic [spc_pkg::CW-1:0]       ofs_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nrm_ff <= '0;
         ofs_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            spc_pkg::REG_NORMAL_X:  nrm_ff[0] <= csr_data;
            spc_pkg::REG_NORMAL_Y:  nrm_ff[1] <= csr_data;
            spc_pkg::REG_NORMAL_Z:  nrm_ff[2] <= csr_data;
            spc_pkg::REG_PLANE_OFS: ofs_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipe advances whenever the skid slot is free
   logic adv;
   logic skid_v_ff;

   assign adv       = !skid_v_ff;
   assign req_ready = adv;

   spc_pkg::seg_type in_seg;
   assign in_seg.a = {req_a_z, req_a_y, req_a_x};
   assign in_seg.b = {req_b_z, req_b_y, req_b_x};

   logic                       dot_v;
   spc_pkg::seg_type           dot_seg;
   spc_pkg::ctl_type           dot_ctl;
   logic [spc_pkg::MW-1:0]     dot_nm, dot_dm;

   spc_dot u_dot (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_v    (req_valid),
      .in_seg  (in_seg),
      .nrm     (nrm_ff),
      .ofs     (ofs_ff),
      .out_v   (dot_v),
      .out_seg (dot_seg),
      .out_ctl (dot_ctl),
      .out_nm  (dot_nm),
      .out_dm  (dot_dm)
   );

   logic                       div_v;
   spc_pkg::seg_type           div_seg;
   spc_pkg::ctl_type           div_ctl;
   logic [spc_pkg::FB-1:0]     div_q;

   spc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_v    (dot_v),
      .in_seg  (dot_seg),
      .in_ctl  (dot_ctl),
      .in_nm   (dot_nm),
      .in_dm   (dot_dm),
      .out_v   (div_v),
      .out_seg (div_seg),
      .out_ctl (div_ctl),
      .out_q   (div_q)
   );

   logic                       ip_v;
   spc_pkg::res_type           ip_res;

   spc_interp u_interp (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_v    (div_v),
      .in_seg  (div_seg),
      .in_ctl  (div_ctl),
      .in_q    (div_q),
      .out_v   (ip_v),
      .out_res (ip_res)
   );

   // Output register plus one skid entry
   logic                 out_v_ff;
   spc_pkg::res_type     out_ff;
   spc_pkg::res_type     skid_ff;
   logic                 arrive, out_free;

   assign arrive   = adv && ip_v;
   assign out_free = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= arrive;
         end
      end else if (arrive) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : ip_res;
      end
      if (!out_free && arrive) begin
         skid_ff <= ip_res;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_kept    = out_ff.kept;
   assign rsp_out_a_x = out_ff.seg.a[0];
   assign rsp_out_a_y = out_ff.seg.a[1];
   assign rsp_out_a_z = out_ff.seg.a[2];
   assign rsp_out_b_x = out_ff.seg.b[0];
   assign rsp_out_b_y = out_ff.seg.b[1];
   assign rsp_out_b_z = out_ff.seg.b[2];

endmodule
